>>> rtl/aa55_pkg.sv
`timescale 1ns / 1ps

package aa55_pkg;

	// Frame layout
	localparam logic [7:0] HDR_FIRST     = 8'hAA;
	localparam logic [7:0] HDR_SECOND    = 8'h55;
	localparam int         FRAME_MIN_LEN = 9;
	localparam int         DEF_FRAME_MAX_LEN = 64;

	// Byte positions inside the body store (the body starts at the length byte)
	localparam int POS_LEN     = 0;
	localparam int POS_ADDR    = 1;
	localparam int POS_SEQ     = 2;
	localparam int POS_CMD     = 3;
	localparam int POS_CTRL    = 4;
	localparam int PAYLOAD_OFS = 5;

	// CRC-16/MODBUS
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;

	// Register defaults and indexes
	localparam logic [7:0] DEF_DEVICE_ADDRESS = 8'd1;
	localparam logic [7:0] DEF_TIMEOUT_TICKS  = 8'd50;
	localparam int         CFG_IDX_W          = 1;
	localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDRESS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS  = 1'd1;

	// Input item kinds
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Frame status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ADDR = 2'd1;
	localparam logic [1:0] ST_CRC  = 2'd2;

	// Output tdata width: status, four header bytes, count, payload byte
	localparam int OUT_DATA_W = 48;

	// Header and status of the last completed frame
	typedef struct packed {
		logic [1:0] status;
		logic [7:0] frame_len;
		logic [7:0] addr;
		logic [7:0] seq;
		logic [7:0] cmd;
		logic [7:0] ctrl;
	} frame_info_t;

	// One byte through the reflected CRC, bit by bit
	function automatic logic [15:0] crc16_feed(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0])
				c = (c >> 1) ^ CRC_POLY;
			else
				c = c >> 1;
		end
		return c;
	endfunction

endpackage

>>> rtl/aa55_body_ram.sv
`timescale 1ns / 1ps

module aa55_body_ram #(
	parameter int DEPTH = 62,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

>>> rtl/aa55_rx_parse.sv
`timescale 1ns / 1ps

module aa55_rx_parse #(
	parameter int FRAME_MAX_LEN = 64,
	parameter int BODY_DEPTH    = FRAME_MAX_LEN - 2,
	parameter int IDX_W         = $clog2(BODY_DEPTH)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 acc,
	input  logic                 op,
	input  logic [7:0]           rx_byte,
	input  logic [7:0]           dev_addr,
	input  logic [7:0]           tmo_ticks,
	output logic                 ram_we,
	output logic [IDX_W-1:0]     ram_waddr,
	output logic [7:0]           ram_wdata,
	output logic                 done,
	output aa55_pkg::frame_info_t info
);

	import aa55_pkg::*;

	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_WAIT55 = 2'd1;
	localparam logic [1:0] PH_BODY   = 2'd2;

	logic [1:0]       phase_q;
	logic [7:0]       gap_q;
	logic [IDX_W-1:0] idx_q;
	logic [15:0]      crc_q;
	logic [7:0]       crc_lo_q;
	logic [7:0]       len_q;
	logic [7:0]       addr_q, seq_q, cmd_q, ctrl_q;
	logic [1:0]       status_q;
	logic             done_q;

	logic [7:0]  gap_dec;
	logic [7:0]  idx_ext;
	logic        len_bad;
	logic        is_last;
	logic        feed_crc;
	logic [15:0] crc_next;

	assign gap_dec  = (gap_q != 8'd0) ? gap_q - 8'd1 : gap_q;
	assign idx_ext  = 8'(idx_q);
	assign len_bad  = (rx_byte < 8'(FRAME_MIN_LEN)) || (rx_byte > 8'(FRAME_MAX_LEN));
	assign is_last  = (idx_ext == len_q - 8'd3);
	assign feed_crc = (idx_ext < len_q - 8'd4);
	assign crc_next = crc16_feed(crc_q, rx_byte);

	// Every body byte goes to the store at the running index
	assign ram_we    = acc && (op == OP_BYTE) && (phase_q == PH_BODY);
	assign ram_waddr = idx_q;
	assign ram_wdata = rx_byte;

	// Control: phase, inter-byte timer, index, done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			gap_q   <= 8'd0;
			idx_q   <= '0;
			crc_q   <= CRC_INIT;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (acc) begin
				if (op == OP_TICK) begin
					gap_q <= gap_dec;
					if (phase_q != PH_IDLE && gap_dec == 8'd0)
						phase_q <= PH_IDLE;
				end else begin
					case (phase_q)
						PH_IDLE: begin
							if (rx_byte == HDR_FIRST) begin
								phase_q <= PH_WAIT55;
								gap_q   <= tmo_ticks;
							end
						end
						PH_WAIT55: begin
							gap_q <= tmo_ticks;
							if (rx_byte == HDR_SECOND) begin
								phase_q <= PH_BODY;
								idx_q   <= '0;
								crc_q   <= CRC_INIT;
							end else if (rx_byte != HDR_FIRST) begin
								phase_q <= PH_IDLE;
								gap_q   <= 8'd0;
							end
						end
						PH_BODY: begin
							gap_q <= tmo_ticks;
							idx_q <= idx_q + IDX_W'(1);
							if (idx_q == IDX_W'(POS_LEN)) begin
								if (len_bad) begin
									phase_q <= PH_IDLE;
									gap_q   <= 8'd0;
								end else begin
									crc_q <= crc_next;
								end
							end else if (is_last) begin
								phase_q <= PH_IDLE;
								gap_q   <= 8'd0;
								done_q  <= 1'b1;
							end else if (feed_crc) begin
								crc_q <= crc_next;
							end
						end
						default: begin
							phase_q <= PH_IDLE;
							gap_q   <= 8'd0;
						end
					endcase
				end
			end
		end
	end

	// Header bytes, CRC low byte and frame status
	always_ff @(posedge clk) begin
		if (ram_we) begin
			if (idx_q == IDX_W'(POS_LEN))  len_q  <= rx_byte;
			if (idx_q == IDX_W'(POS_ADDR)) addr_q <= rx_byte;
			if (idx_q == IDX_W'(POS_SEQ))  seq_q  <= rx_byte;
			if (idx_q == IDX_W'(POS_CMD))  cmd_q  <= rx_byte;
			if (idx_q == IDX_W'(POS_CTRL)) ctrl_q <= rx_byte;
			if (idx_q != IDX_W'(POS_LEN) && idx_ext == len_q - 8'd4)
				crc_lo_q <= rx_byte;
			if (idx_q != IDX_W'(POS_LEN) && is_last) begin
				if ({rx_byte, crc_lo_q} != crc_q)
					status_q <= ST_CRC;
				else if (addr_q != dev_addr)
					status_q <= ST_ADDR;
				else
					status_q <= ST_OK;
			end
		end
	end

	assign done             = done_q;
	assign info.status      = status_q;
	assign info.frame_len   = len_q;
	assign info.addr        = addr_q;
	assign info.seq         = seq_q;
	assign info.cmd         = cmd_q;
	assign info.ctrl        = ctrl_q;

endmodule

>>> rtl/aa55_frame_receiver_crc16.sv
`timescale 1ns / 1ps

// Receives a byte stream of AA 55 frames (length, address, sequence, command,
// control, payload, CRC-16/MODBUS low byte first) mixed with timer ticks, and
// reports each completed frame: one item with its header and status, or, when
// the status is ok and there is payload, one item per payload byte with the
// header repeated and the final one marked tlast. Bytes and ticks are taken
// one per clock cycle while a frame is being received; the payload lands in a
// one-port-write, one-port-read body memory with registered read data. When a
// frame completes, input is held off while the result is latched and then
// while it is drained: each payload byte passes through a memory read, then the
// output register, before the next read starts, stretched by any backpressure
// on the output. No clearing pass follows reset.
module aa55_frame_receiver_crc16 #(
	parameter int FRAME_MAX_LEN = aa55_pkg::DEF_FRAME_MAX_LEN
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [7:0]                         s_axis_tdata,  // [7:0] rx_byte
	input  logic                               s_axis_tuser,  // [0] operation
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// [1:0] frame_status, [9:2] frame_addr, [17:10] frame_seq, [25:18] frame_cmd,
	// [33:26] frame_ctrl, [39:34] payload_count, [47:40] payload_byte
	output logic [aa55_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	output logic                               m_axis_tuser,  // [0] payload_valid
	output logic                               m_axis_tlast,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [aa55_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [7:0]                         cfg_wdata
);

	import aa55_pkg::*;

	localparam int BODY_DEPTH = FRAME_MAX_LEN - 2;
	localparam int IDX_W      = $clog2(BODY_DEPTH);

	logic [7:0] dev_addr_q, tmo_q;

	logic             acc;
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [7:0]       ram_wdata;
	logic             ram_re;
	logic [IDX_W-1:0] ram_raddr;
	logic [7:0]       ram_rdata;
	logic             done;
	frame_info_t      info;

	logic             drain_q;
	logic [IDX_W-1:0] pidx_q;
	logic             rd_pend_s1;
	logic             rd_last_s1;

	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic                  out_user_q;
	logic                  out_last_q;

	logic       out_free;
	logic       single;
	logic [7:0] count;
	logic       issue_last;
	logic       load_single;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= DEF_DEVICE_ADDRESS;
			tmo_q      <= DEF_TIMEOUT_TICKS;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DEVICE_ADDRESS: dev_addr_q <= cfg_wdata;
				REG_TIMEOUT_TICKS:  tmo_q      <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Input side is held while a completed frame is latched or drained
	assign s_axis_tready = !drain_q && !done && !rd_pend_s1;
	assign acc           = s_axis_tvalid && s_axis_tready;

	aa55_rx_parse #(
		.FRAME_MAX_LEN(FRAME_MAX_LEN),
		.BODY_DEPTH   (BODY_DEPTH),
		.IDX_W        (IDX_W)
	) u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc      (acc),
		.op       (s_axis_tuser),
		.rx_byte  (s_axis_tdata),
		.dev_addr (dev_addr_q),
		.tmo_ticks(tmo_q),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.done     (done),
		.info     (info)
	);

	aa55_body_ram #(
		.DEPTH(BODY_DEPTH),
		.AW   (IDX_W)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Drain sequencer
	assign count       = info.frame_len - 8'(FRAME_MIN_LEN);
	assign single      = (info.status != ST_OK) || (count == 8'd0);
	assign out_free    = !out_valid_q || m_axis_tready;
	assign load_single = drain_q && single && out_free;
	assign ram_re      = drain_q && !single && !rd_pend_s1 && out_free;
	assign ram_raddr   = IDX_W'(PAYLOAD_OFS) + pidx_q;
	assign issue_last  = (8'(pidx_q) + 8'd1 == count);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_q    <= 1'b0;
			pidx_q     <= '0;
			rd_pend_s1 <= 1'b0;
			rd_last_s1 <= 1'b0;
		end else begin
			rd_pend_s1 <= ram_re;
			if (done) begin
				drain_q <= 1'b1;
				pidx_q  <= '0;
			end else if (load_single) begin
				drain_q <= 1'b0;
			end else if (ram_re) begin
				pidx_q     <= pidx_q + IDX_W'(1);
				rd_last_s1 <= issue_last;
				if (issue_last)
					drain_q <= 1'b0;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_single || rd_pend_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_single) begin
			out_data_q <= {8'd0, count[5:0], info.ctrl, info.cmd, info.seq, info.addr,
				info.status};
			out_user_q <= 1'b0;
			out_last_q <= 1'b1;
		end else if (rd_pend_s1) begin
			out_data_q <= {ram_rdata, count[5:0], info.ctrl, info.cmd, info.seq, info.addr,
				info.status};
			out_user_q <= 1'b1;
			out_last_q <= rd_last_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;
	assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
	// Read data never lands on an output item still waiting
	assert property (@(posedge clk) disable iff (!arst_n) rd_pend_s1 |-> !out_valid_q)
		else $error("payload read collides with a held output item");

	// A frame completes only when no drain is in flight
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !drain_q && !rd_pend_s1)
		else $error("frame completed during drain");

	// A status-only item is always the last of its frame
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
		else $error("status item not marked last");

	// Payload items only come from frames with good status
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[1:0] == ST_OK)
		else $error("payload item with bad status");

	// Body memory is never written while it is being drained
	assert property (@(posedge clk) disable iff (!arst_n) ram_we |-> !drain_q && !rd_pend_s1)
		else $error("body write during drain");
`endif

endmodule
